// ----- hdl/serial_frame_receiver_core_defines.svh -----
// Assertion macros for the serial frame receiver.
// Included by the top level; depends on nothing else.
`ifndef SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, held off during reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// ----- hdl/sfr_pkg.sv -----
// Shared types, constants and helpers for the serial frame receiver.
// No dependencies; imported by the parser, the emitter and the top level.
package sfr_pkg;

  localparam int SFR_MAX_PAYLOAD  = 16;
  localparam int SFR_RUN_LIMIT    = 16;
  localparam int SFR_HEADER_BYTES = 5;

  localparam logic [7:0] SFR_CHECK_BASE   = 8'hFC;
  localparam logic [7:0] SFR_SYNC_RESET   = 8'hFC;
  localparam logic [7:0] SFR_PRE1_RESET   = 8'h01;
  localparam logic [7:0] SFR_PRE2_RESET   = 8'h30;
  localparam logic [4:0] SFR_MAXLEN_RESET = 5'd16;

  // result status codes
  localparam logic [2:0] ST_PAYLOAD  = 3'd0;
  localparam logic [2:0] ST_EMPTY_OK = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_PREAMBLE = 3'd4;
  localparam logic [2:0] ST_OVERSIZE = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_SYNC   = 3'd0;
  localparam logic [2:0] CFG_PRE1   = 3'd1;
  localparam logic [2:0] CFG_PRE2   = 3'd2;
  localparam logic [2:0] CFG_MAXLEN = 3'd3;

  // frame positions
  localparam logic [4:0] POS_SYNC    = 5'd0;
  localparam logic [4:0] POS_TYPE    = 5'd1;
  localparam logic [4:0] POS_PRE1    = 5'd2;
  localparam logic [4:0] POS_PRE2    = 5'd3;
  localparam logic [4:0] POS_LEN     = 5'd4;
  localparam logic [4:0] POS_PAYLOAD = 5'(SFR_HEADER_BYTES);

  localparam logic [7:0] SFR_KNOWN_TYPES [8] = '{
    8'h41, 8'h61, 8'h42, 8'h62, 8'h5A, 8'h7A, 8'h5B, 8'h7B
  };

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] preamble_first;
    logic [7:0] preamble_second;
    logic [4:0] max_payload_len;
  } sfr_cfg_t;

  // one frame event from the parser to the emitter
  typedef struct packed {
    logic       valid;
    logic       run;     // good frame with payload: play back the store
    logic [2:0] status;
    logic [7:0] ftype;
    logic [4:0] len;
  } sfr_event_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_FETCH,
    EM_SHOW
  } sfr_emit_state_t;

  function automatic logic sfr_is_known(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (SFR_KNOWN_TYPES[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- hdl/sfr_ram.sv -----
// Payload store: single write port, one registered read port.
// Depends on nothing; contents undefined until written.
module sfr_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/sfr_parser.sv -----
// Frame parser: header checks, running checksum, payload writes to the store.
// Depends on sfr_pkg; emits one event per frame end or error.
module sfr_parser #(
  parameter int CAP = 16,
  parameter int AW  = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_pkg::sfr_cfg_t  cfg,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output sfr_pkg::sfr_event_t ev
);
  import sfr_pkg::*;

  localparam logic [4:0] CAP5 = 5'(CAP);

  logic [4:0] pos_r, pos_nxt;
  logic [4:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic [4:0] limit;
  logic [4:0] slot;
  logic [7:0] expect_sum;

  assign limit      = (cfg.max_payload_len > CAP5) ? CAP5 : cfg.max_payload_len;
  assign slot       = pos_r - POS_PAYLOAD;
  assign expect_sum = SFR_CHECK_BASE - sum_r;
  assign wr_data    = rx_byte;
  assign wr_addr    = slot[AW-1:0];

  // per-byte decode
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r + rx_byte;
    wr_en     = 1'b0;
    ev        = '0;
    ev.ftype  = type_r;
    case (pos_r)
      POS_SYNC: begin
        sum_nxt = rx_byte;
        if (rx_byte == cfg.sync_value) pos_nxt = POS_TYPE;
      end
      POS_TYPE: begin
        if (sfr_is_known(rx_byte)) begin
          type_nxt = rx_byte;
          pos_nxt  = POS_PRE1;
        end else begin
          pos_nxt   = POS_SYNC;
          ev.valid  = 1'b1;
          ev.status = ST_UNKNOWN;
          ev.ftype  = rx_byte;
        end
      end
      POS_PRE1, POS_PRE2: begin
        if (rx_byte == ((pos_r == POS_PRE1) ? cfg.preamble_first : cfg.preamble_second)) begin
          pos_nxt = pos_r + 5'd1;
        end else begin
          pos_nxt   = POS_SYNC;
          ev.valid  = 1'b1;
          ev.status = ST_PREAMBLE;
        end
      end
      POS_LEN: begin
        if (rx_byte > {3'b000, limit}) begin
          pos_nxt   = POS_SYNC;
          ev.valid  = 1'b1;
          ev.status = ST_OVERSIZE;
          ev.len    = (|rx_byte[7:5]) ? 5'd31 : rx_byte[4:0];
        end else begin
          len_nxt = rx_byte[4:0];
          pos_nxt = POS_PAYLOAD;
        end
      end
      default: begin
        if (pos_r < POS_PAYLOAD + len_r) begin
          // payload byte into the store
          wr_en   = accept;
          pos_nxt = pos_r + 5'd1;
        end else begin
          // checksum byte closes the frame
          pos_nxt  = POS_SYNC;
          ev.valid = 1'b1;
          ev.len   = len_r;
          if (rx_byte != expect_sum) begin
            ev.status = ST_CHECKSUM;
          end else if (len_r == 5'd0) begin
            ev.status = ST_EMPTY_OK;
          end else begin
            ev.status = ST_PAYLOAD;
            ev.run    = 1'b1;
          end
        end
      end
    endcase
    ev.valid = ev.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_SYNC;
      len_r  <= '0;
      type_r <= '0;
      sum_r  <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      type_r <= type_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ----- hdl/sfr_emitter.sv -----
// Result emitter: output register, payload run playback from the store.
// Depends on sfr_pkg; reads the store one entry per payload result.
module sfr_emitter #(
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfr_pkg::sfr_event_t ev,
  input  logic [7:0]          rd_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_frame_status,
  output logic [7:0]          out_frame_type,
  output logic [4:0]          out_payload_len,
  output logic [3:0]          out_byte_index,
  output logic [7:0]          out_payload_value,
  output logic                out_last_of_run
);
  import sfr_pkg::*;

  sfr_emit_state_t state_r, state_nxt;

  logic [2:0] status_r, status_nxt;
  logic [7:0] type_r, type_nxt;
  logic [4:0] len_r, len_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] value_r, value_nxt;
  logic       last_r, last_nxt;
  logic       taken;
  logic       advance;

  assign taken   = (state_r == EM_SHOW) && !out_stall;
  assign advance = taken && !last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (ev.valid) state_nxt = ev.run ? EM_FETCH : EM_SHOW;
      end
      EM_FETCH: begin
        state_nxt = EM_SHOW;
      end
      EM_SHOW: begin
        if (advance) begin
          state_nxt = EM_FETCH;
        end else if (taken) begin
          if (ev.valid) state_nxt = ev.run ? EM_FETCH : EM_SHOW;
          else          state_nxt = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  // outputs and store reads
  always_comb begin
    in_stall  = !((state_r == EM_IDLE) || (taken && last_r));
    out_valid = (state_r == EM_SHOW);
    rd_en     = (ev.valid && ev.run) || advance;
    rd_addr   = ev.valid ? '0 : idx_nxt[AW-1:0];
  end

  // result word fields
  always_comb begin
    status_nxt = status_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r + 4'd1;
    value_nxt  = value_r;
    last_nxt   = last_r;
    if (ev.valid) begin
      status_nxt = ev.status;
      type_nxt   = ev.ftype;
      len_nxt    = ev.len;
      idx_nxt    = '0;
      value_nxt  = '0;
      last_nxt   = !ev.run || (ev.len == 5'd1);
    end else if (state_r == EM_FETCH) begin
      idx_nxt   = idx_r;
      value_nxt = rd_data;
    end else if (advance) begin
      last_nxt = ({1'b0, idx_r} + 5'd2) == len_r;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    type_r   <= type_nxt;
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
  end

  assign out_frame_status  = status_r;
  assign out_frame_type    = type_r;
  assign out_payload_len   = len_r;
  assign out_byte_index    = idx_r;
  assign out_payload_value = value_r;
  assign out_last_of_run   = last_r;

endmodule

// ----- hdl/serial_frame_receiver_core.sv -----
// Top level of the serial frame receiver: config registers, parser, store, emitter.
// Depends on sfr_pkg, sfr_parser, sfr_ram, sfr_emitter and the defines header.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid / in_stall     | in_rx_byte
//  out     | out_valid / out_stall   | status, type, len, byte_index, value, last
//  cfg     | cfg_wr_en               | cfg_index, cfg_data
//
// Header and payload bytes are taken one word per cycle while in_stall is low.
// A byte that ends a frame with an error or an empty frame gives one result; the
// next byte is taken in the cycle that result leaves the output register.
// A good frame of n payload bytes plays back from the store as n results (store read,
// then output register), n up to 16, each held as long as out_stall is raised.
// Input stalls while a run plays, so store writes and reads never overlap.
// Reset is synchronous; the store needs no clearing pass.
module serial_frame_receiver_core #(
  parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_type,
  output logic [4:0] out_payload_len,
  output logic [3:0] out_byte_index,
  output logic [7:0] out_payload_value,
  output logic       out_last_of_run,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sfr_pkg::*;
  `include "serial_frame_receiver_core_defines.svh"

  localparam int CAP = (MAX_PAYLOAD < SFR_RUN_LIMIT) ? MAX_PAYLOAD : SFR_RUN_LIMIT;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

  sfr_cfg_t   cfg_r;
  sfr_event_t ev;
  logic       in_accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value      <= SFR_SYNC_RESET;
      cfg_r.preamble_first  <= SFR_PRE1_RESET;
      cfg_r.preamble_second <= SFR_PRE2_RESET;
      cfg_r.max_payload_len <= SFR_MAXLEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SYNC:   cfg_r.sync_value      <= cfg_data;
        CFG_PRE1:   cfg_r.preamble_first  <= cfg_data;
        CFG_PRE2:   cfg_r.preamble_second <= cfg_data;
        CFG_MAXLEN: cfg_r.max_payload_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sfr_parser #(.CAP(CAP), .AW(AW)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ev      (ev)
  );

  sfr_ram #(.DEPTH(CAP), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfr_emitter #(.AW(AW)) u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev                (ev),
    .rd_data           (rd_data),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_frame_type    (out_frame_type),
    .out_payload_len   (out_payload_len),
    .out_byte_index    (out_byte_index),
    .out_payload_value (out_payload_value),
    .out_last_of_run   (out_last_of_run)
  );

  // a new byte is never taken while an untaken result still waits
  `SFR_ASSERT_NOW(a_no_accept_over_result, clk, rst_n, in_accept, !(out_valid && out_stall))
  // only payload words may leave a run open
  `SFR_ASSERT_NOW(a_open_run_is_payload, clk, rst_n, out_valid && !out_last_of_run, out_frame_status == ST_PAYLOAD)
  // payload words stay inside the frame length
  `SFR_ASSERT_NOW(a_index_in_length, clk, rst_n, out_valid && out_frame_status == ST_PAYLOAD, {1'b0, out_byte_index} < out_payload_len)
  // store writes never happen while a run is playing back
  `SFR_ASSERT_NEXT(a_no_write_in_run, clk, rst_n, rd_en, !wr_en)

endmodule
